### rtl/core/sle_pkg.sv
// Shared constants, event codes and the scancode-to-ASCII key map for the line editor.
`timescale 1ns / 1ps

package sle_pkg;

	localparam int unsigned SCAN_W = 8;
	localparam int unsigned CHAR_W = 7;
	localparam int unsigned EVENT_W = 2;
	localparam int unsigned LEN_W = 9;

	// Scan code set 1 bytes with a meaning of their own.
	localparam logic [SCAN_W-1:0] CODE_PREFIX = 8'hE0;
	localparam logic [SCAN_W-1:0] CODE_DELETE = 8'h53;
	localparam logic [SCAN_W-1:0] CODE_BACKSPACE = 8'h0E;
	localparam logic [SCAN_W-1:0] CODE_ENTER = 8'h1C;
	localparam logic [SCAN_W-1:0] KEY_MAP_LEN = 8'd58;

	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'h0A;
	localparam logic [CHAR_W-1:0] CHAR_NONE = 7'h00;

	typedef logic [EVENT_W-1:0] event_t;
	localparam event_t EV_NONE = 2'd0;
	localparam event_t EV_APPEND = 2'd1;
	localparam event_t EV_REMOVE = 2'd2;
	localparam event_t EV_FULL = 2'd3;

	// AZERTY map for make codes below KEY_MAP_LEN. Zero means the key has no character.
	function automatic logic [CHAR_W-1:0] key_map(input logic [5:0] code);
		logic [CHAR_W-1:0] ch;
		case (code)
			6'd1:  ch = 7'h1B;  // escape
			6'd2:  ch = 7'h31;
			6'd3:  ch = 7'h32;
			6'd4:  ch = 7'h33;
			6'd5:  ch = 7'h34;
			6'd6:  ch = 7'h35;
			6'd7:  ch = 7'h36;
			6'd8:  ch = 7'h37;
			6'd9:  ch = 7'h38;
			6'd10: ch = 7'h39;
			6'd11: ch = 7'h30;
			6'd12: ch = 7'h2D;
			6'd13: ch = 7'h3D;
			6'd14: ch = 7'h08;
			6'd15: ch = 7'h09;
			6'd16: ch = 7'h61;
			6'd17: ch = 7'h7A;
			6'd18: ch = 7'h65;
			6'd19: ch = 7'h72;
			6'd20: ch = 7'h74;
			6'd21: ch = 7'h79;
			6'd22: ch = 7'h75;
			6'd23: ch = 7'h69;
			6'd24: ch = 7'h6F;
			6'd25: ch = 7'h70;
			6'd26: ch = 7'h5B;
			6'd27: ch = 7'h5D;
			6'd28: ch = 7'h0A;
			6'd30: ch = 7'h71;
			6'd31: ch = 7'h73;
			6'd32: ch = 7'h64;
			6'd33: ch = 7'h66;
			6'd34: ch = 7'h67;
			6'd35: ch = 7'h68;
			6'd36: ch = 7'h6A;
			6'd37: ch = 7'h6B;
			6'd38: ch = 7'h6C;
			6'd39: ch = 7'h6D;
			6'd40: ch = 7'h27;
			6'd41: ch = 7'h60;
			6'd43: ch = 7'h5C;
			6'd44: ch = 7'h77;
			6'd45: ch = 7'h78;
			6'd46: ch = 7'h63;
			6'd47: ch = 7'h76;
			6'd48: ch = 7'h62;
			6'd49: ch = 7'h6E;
			6'd50: ch = 7'h3B;
			6'd51: ch = 7'h2C;
			6'd52: ch = 7'h2E;
			6'd53: ch = 7'h2F;
			6'd55: ch = 7'h2A;
			6'd57: ch = 7'h20;
			default: ch = CHAR_NONE;
		endcase
		return ch;
	endfunction

endpackage

### rtl/core/sle_scan_if.sv
// Input channel carrying one keyboard scancode per beat.
`timescale 1ns / 1ps

interface sle_scan_if;
	logic                      valid;
	logic                      ready;
	logic [sle_pkg::SCAN_W-1:0] scancode;

	modport source (output valid, output scancode, input ready);
	modport sink (input valid, input scancode, output ready);
endinterface

### rtl/core/sle_result_if.sv
// Output channel carrying one edit report per beat.
`timescale 1ns / 1ps

interface sle_result_if;
	logic                       valid;
	logic                       ready;
	logic [sle_pkg::EVENT_W-1:0] event_res;
	logic [sle_pkg::CHAR_W-1:0]  char_code;
	logic [sle_pkg::LEN_W-1:0]   line_length;

	modport source (output valid, output event_res, output char_code, output line_length,
		input ready);
	modport sink (input valid, input event_res, input char_code, input line_length,
		output ready);
endinterface

### rtl/core/scancode_line_editor.sv
// Top level of the scancode line editor: decode, line memory and result register.
`timescale 1ns / 1ps

// Channel   Dir  Payload                               Meaning
// scan      in   scancode[7:0]                         raw set 1 byte, bit 7 marks release
// result    out  event_res[1:0] char_code[6:0]         edit event and its character
//                line_length[8:0]                      line length after the edit
//
// One beat is taken per cycle while scan.ready is high; each gives exactly one result beat.
// The byte is decoded against the live length and prefix flag in the cycle it
// is taken, so the line memory sees one write (append) or one read (remove) per beat.
// The read data comes back in the following stage and then lands in the output register.
// arst_n clears the length, the prefix flag and both valid bits; the memory is not
// cleared, since only entries below the length are ever read. A stalled result holds
// both stages, and scan.ready drops only when both stages are full and result.ready is low.

module scancode_line_editor #(
	parameter int unsigned LINE_CAPACITY = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	sle_scan_if.sink            scan,
	sle_result_if.source        result
);

	localparam int unsigned CNT_W = $clog2(LINE_CAPACITY + 1);
	localparam int unsigned ADDR_W = $clog2(LINE_CAPACITY);
	localparam logic [CNT_W-1:0] CAP_LIMIT = CNT_W'(LINE_CAPACITY);
	// A newline is only taken while more than three slots remain free.
	localparam logic [CNT_W-1:0] ENTER_LIMIT = CNT_W'(LINE_CAPACITY - 3);

	// Architectural state of the editor.
	logic [CNT_W-1:0] count_q;
	logic             prefix_q;

	// Line memory, one character per entry.
	logic [sle_pkg::CHAR_W-1:0] line_mem [LINE_CAPACITY];

	// Stage 1: decoded beat waiting for the memory read data.
	logic                       valid_s1;
	sle_pkg::event_t            event_s1;
	logic [sle_pkg::CHAR_W-1:0] char_s1;
	logic [CNT_W-1:0]           len_s1;
	logic [sle_pkg::CHAR_W-1:0] rd_data_s1;

	// Output register.
	logic                       out_valid_q;
	sle_pkg::event_t            out_event_q;
	logic [sle_pkg::CHAR_W-1:0] out_char_q;
	logic [sle_pkg::LEN_W-1:0]  out_len_q;

	logic accept;
	logic adv_s1;
	logic out_free;

	// Decode results.
	logic                       prefix_d;
	logic [CNT_W-1:0]           count_d;
	sle_pkg::event_t            event_d;
	logic [sle_pkg::CHAR_W-1:0] char_d;
	logic                       wr_en;
	logic                       rd_en;
	logic [ADDR_W-1:0]          wr_addr;
	logic [ADDR_W-1:0]          rd_addr;

	logic [sle_pkg::SCAN_W-1:0] code;
	logic [sle_pkg::CHAR_W-1:0] map_char;
	logic                       do_remove;
	logic                       do_append;
	logic [CNT_W-1:0]           app_limit;
	logic [sle_pkg::CHAR_W-1:0] app_char;
	logic [CNT_W-1:0]           count_dec;
	logic [CNT_W+sle_pkg::LEN_W-1:0] len_wide;

	// Handshake: the output register frees when it is empty or being drained, stage 1
	// moves forward whenever the output register is free, and a new beat enters stage 1
	// whenever stage 1 is empty or moving.
	assign out_free = !out_valid_q || result.ready;
	assign adv_s1 = valid_s1 && out_free;
	assign scan.ready = !valid_s1 || out_free;
	assign accept = scan.valid && scan.ready;

	assign code = scan.scancode;
	assign map_char = (code < sle_pkg::KEY_MAP_LEN) ? sle_pkg::key_map(code[5:0])
		: sle_pkg::CHAR_NONE;
	assign count_dec = count_q - CNT_W'(1);

	// Byte classification. The prefix byte always re-arms the flag; any other byte
	// after a prefix is consumed, deleting only when it is the extended Delete make code.
	always_comb begin
		prefix_d = prefix_q;
		do_remove = 1'b0;
		do_append = 1'b0;
		app_limit = CAP_LIMIT;
		app_char = map_char;
		if (code == sle_pkg::CODE_PREFIX) begin
			prefix_d = 1'b1;
		end else if (prefix_q) begin
			prefix_d = 1'b0;
			do_remove = (code == sle_pkg::CODE_DELETE);
		end else if (code[sle_pkg::SCAN_W-1]) begin
			// Release codes are dropped.
		end else if (code == sle_pkg::CODE_BACKSPACE) begin
			do_remove = 1'b1;
		end else if (code == sle_pkg::CODE_ENTER) begin
			do_append = 1'b1;
			app_limit = ENTER_LIMIT;
			app_char = sle_pkg::CHAR_NEWLINE;
		end else if (map_char != sle_pkg::CHAR_NONE) begin
			do_append = 1'b1;
		end
	end

	// Edit of the length and the memory access it implies.
	always_comb begin
		count_d = count_q;
		event_d = sle_pkg::EV_NONE;
		char_d = sle_pkg::CHAR_NONE;
		wr_en = 1'b0;
		rd_en = 1'b0;
		wr_addr = count_q[ADDR_W-1:0];
		rd_addr = count_dec[ADDR_W-1:0];
		if (do_remove) begin
			if (count_q != '0) begin
				count_d = count_dec;
				event_d = sle_pkg::EV_REMOVE;
				rd_en = 1'b1;
			end
		end else if (do_append) begin
			if (count_q < app_limit) begin
				count_d = count_q + CNT_W'(1);
				event_d = sle_pkg::EV_APPEND;
				char_d = app_char;
				wr_en = 1'b1;
			end else begin
				event_d = sle_pkg::EV_FULL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			prefix_q <= 1'b0;
		end else if (accept) begin
			count_q <= count_d;
			prefix_q <= prefix_d;
		end
	end

	// One access per accepted beat: the write of an append or the read of a removal.
	// A later beat touches the memory only on a later edge, so a removal right after an
	// append reads the character that append already stored.
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			line_mem[wr_addr] <= char_d;
		end
		if (accept && rd_en) begin
			rd_data_s1 <= line_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			event_s1 <= event_d;
			char_s1 <= char_d;
			len_s1 <= count_d;
		end
	end

	// The reported length is the count masked to the port width.
	assign len_wide = {{sle_pkg::LEN_W{1'b0}}, len_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_event_q <= event_s1;
			out_char_q <= (event_s1 == sle_pkg::EV_REMOVE) ? rd_data_s1 : char_s1;
			out_len_q <= len_wide[sle_pkg::LEN_W-1:0];
		end
	end

	assign result.valid = out_valid_q;
	assign result.event_res = out_event_q;
	assign result.char_code = out_char_q;
	assign result.line_length = out_len_q;

endmodule

### dv/scancode_line_editor_test.sv
// Self-checking testbench for the scancode line editor: random and directed scancodes.
`timescale 1ns / 1ps

module scancode_line_editor_test;

	localparam int unsigned LINE_CAP = 256;
	localparam int unsigned LINE_AW = $clog2(LINE_CAP);
	localparam int unsigned CLK_HALF = 10;
	localparam int unsigned SETTLE_CYCLES = 10;

	// Set 1 make codes below KEY_MAP_LEN and their AZERTY characters. Zero marks a key
	// with no character of its own.
	localparam logic [sle_pkg::CHAR_W-1:0] AZERTY_CHARS [0:57] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
		7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h61, 7'h7A, 7'h65, 7'h72,
		7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
		7'h71, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h6D,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h77, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
		7'h3B, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
	};

	typedef struct packed {
		sle_pkg::event_t            ev;
		logic [sle_pkg::CHAR_W-1:0] ch;
		logic [sle_pkg::LEN_W-1:0]  len;
	} edit_report_t;

	logic clk = 1'b0;
	logic arst_n;

	sle_scan_if   scan_ch ();
	sle_result_if result_ch ();

	scancode_line_editor #(
		.LINE_CAPACITY(LINE_CAP)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.scan   (scan_ch),
		.result (result_ch)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Bytes waiting to be sent, and the edit reports the line should produce.
	logic [sle_pkg::SCAN_W-1:0] scan_bytes [$];
	edit_report_t               expected_edits [$];
	int                         total_bytes;
	int                         beats_taken = 0;
	int                         mismatch_count = 0;

	// Shadow copy of the editor: prefix flag, line length and stored characters.
	logic                       shadow_prefix;
	int unsigned                shadow_len;
	logic [sle_pkg::CHAR_W-1:0] shadow_line [LINE_CAP];

	// While this window of beats passes, neither side idles, so the block runs at full rate.
	logic steady;
	assign steady = (beats_taken >= 150) && (beats_taken < 260);

	function automatic edit_report_t make_report(sle_pkg::event_t ev,
		logic [sle_pkg::CHAR_W-1:0] ch);
		edit_report_t r;
		r.ev = ev;
		r.ch = ch;
		r.len = shadow_len[sle_pkg::LEN_W-1:0];
		return r;
	endfunction

	// Backspace and prefixed Delete both drop the last character, if there is one.
	function automatic edit_report_t drop_last_char();
		if (shadow_len == 0)
			return make_report(sle_pkg::EV_NONE, sle_pkg::CHAR_NONE);
		shadow_len--;
		return make_report(sle_pkg::EV_REMOVE, shadow_line[shadow_len[LINE_AW-1:0]]);
	endfunction

	// Enter has a lower limit than ordinary characters, so the limit is passed in.
	function automatic edit_report_t add_char(logic [sle_pkg::CHAR_W-1:0] ch,
		int unsigned limit);
		if (shadow_len >= limit || shadow_len >= LINE_CAP)
			return make_report(sle_pkg::EV_FULL, sle_pkg::CHAR_NONE);
		shadow_line[shadow_len[LINE_AW-1:0]] = ch;
		shadow_len++;
		return make_report(sle_pkg::EV_APPEND, ch);
	endfunction

	// Works out the report for one accepted scancode and updates the shadow line.
	function automatic edit_report_t predict_edit(logic [sle_pkg::SCAN_W-1:0] code);
		if (code == sle_pkg::CODE_PREFIX) begin
			// A prefix re-arms the flag even when it is already set.
			shadow_prefix = 1'b1;
			return make_report(sle_pkg::EV_NONE, sle_pkg::CHAR_NONE);
		end
		if (shadow_prefix) begin
			// Whatever follows a prefix is consumed; only Delete has an effect.
			shadow_prefix = 1'b0;
			if (code == sle_pkg::CODE_DELETE)
				return drop_last_char();
			return make_report(sle_pkg::EV_NONE, sle_pkg::CHAR_NONE);
		end
		if (code[sle_pkg::SCAN_W-1])
			return make_report(sle_pkg::EV_NONE, sle_pkg::CHAR_NONE);
		if (code == sle_pkg::CODE_BACKSPACE)
			return drop_last_char();
		if (code == sle_pkg::CODE_ENTER)
			return add_char(sle_pkg::CHAR_NEWLINE, LINE_CAP - 3);
		if (code < sle_pkg::KEY_MAP_LEN && AZERTY_CHARS[code[5:0]] != sle_pkg::CHAR_NONE)
			return add_char(AZERTY_CHARS[code[5:0]], LINE_CAP);
		return make_report(sle_pkg::EV_NONE, sle_pkg::CHAR_NONE);
	endfunction

	// A make code with a non-zero table entry, leaving out Backspace and Enter,
	// which have meanings of their own.
	function automatic logic [sle_pkg::SCAN_W-1:0] pick_char_code();
		logic [sle_pkg::SCAN_W-1:0] code;
		do
			code = sle_pkg::SCAN_W'($urandom_range(0, sle_pkg::KEY_MAP_LEN - 1));
		while (AZERTY_CHARS[code[5:0]] == sle_pkg::CHAR_NONE ||
			code == sle_pkg::CODE_BACKSPACE || code == sle_pkg::CODE_ENTER);
		return code;
	endfunction

	task automatic queue_delete();
		if ($urandom_range(0, 1) == 0) begin
			scan_bytes.push_back(sle_pkg::CODE_BACKSPACE);
		end else begin
			scan_bytes.push_back(sle_pkg::CODE_PREFIX);
			scan_bytes.push_back(sle_pkg::CODE_DELETE);
		end
	endtask

	// Anything at all: random bytes, release codes, or a prefix with a random follower.
	task automatic queue_noise();
		case ($urandom_range(0, 2))
			0: scan_bytes.push_back(sle_pkg::SCAN_W'($urandom_range(0, 255)));
			1: scan_bytes.push_back(sle_pkg::SCAN_W'($urandom_range(128, 255)));
			default: begin
				scan_bytes.push_back(sle_pkg::CODE_PREFIX);
				scan_bytes.push_back(sle_pkg::SCAN_W'($urandom_range(0, 255)));
			end
		endcase
	endtask

	// Scan source. A new beat is offered only once the previous one has been taken, so
	// valid never drops while a beat is waiting.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_ch.valid <= 1'b0;
			scan_ch.scancode <= '0;
		end else if (!scan_ch.valid || scan_ch.ready) begin
			if (scan_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= 26)) begin
				scan_ch.valid <= 1'b1;
				scan_ch.scancode <= scan_bytes.pop_front();
			end else begin
				scan_ch.valid <= 1'b0;
			end
		end
	end

	// Result sink with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_ch.ready <= 1'b0;
		else
			result_ch.ready <= steady || ($urandom_range(0, 99) >= 26);
	end

	// Watches both channels. A result beat is checked before the scan beat of the same
	// edge is predicted, so a result can never be matched against its own prediction.
	always @(posedge clk) begin
		edit_report_t want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_edits.size() == 0) begin
					$display("%0t: result beat with nothing expected: ev %0d ch %h len %0d",
						$time, result_ch.event_res, result_ch.char_code,
						result_ch.line_length);
					mismatch_count++;
				end else begin
					want = expected_edits.pop_front();
					if (result_ch.event_res !== want.ev || result_ch.char_code !== want.ch ||
						result_ch.line_length !== want.len) begin
						$display("%0t: expected ev %0d ch %h len %0d, got ev %0d ch %h len %0d",
							$time, want.ev, want.ch, want.len, result_ch.event_res,
							result_ch.char_code, result_ch.line_length);
						mismatch_count++;
					end
				end
			end
			if (scan_ch.valid && scan_ch.ready) begin
				expected_edits.push_back(predict_edit(scan_ch.scancode));
				beats_taken <= beats_taken + 1;
			end
		end
	end

	initial begin
		int unsigned pick;
		shadow_prefix = 1'b0;
		shadow_len = 0;
		arst_n = 1'b0;

		// Directed opening: edits on an empty line, prefix corner cases, release codes,
		// codes outside the key table and the extremes of the byte.
		scan_bytes = '{8'h00, sle_pkg::CODE_BACKSPACE, sle_pkg::CODE_PREFIX,
			sle_pkg::CODE_DELETE, sle_pkg::CODE_ENTER, 8'h10, 8'h39, 8'h01,
			sle_pkg::CODE_PREFIX, sle_pkg::CODE_BACKSPACE, sle_pkg::CODE_PREFIX,
			sle_pkg::CODE_PREFIX, sle_pkg::CODE_DELETE, sle_pkg::CODE_PREFIX, 8'h9C, 8'h90,
			8'hFF, 8'h80, sle_pkg::KEY_MAP_LEN, 8'h7F, 8'h1D, 8'h0F, sle_pkg::CODE_PREFIX,
			sle_pkg::CODE_ENTER, sle_pkg::CODE_BACKSPACE};

		// Typing phase: mostly characters, so the line fills up and then sits at its
		// limit, where Enter and ordinary characters are turned away at different lengths.
		repeat (300) begin
			pick = $urandom_range(0, 99);
			if (pick < 86)
				scan_bytes.push_back(pick_char_code());
			else if (pick < 92)
				scan_bytes.push_back(sle_pkg::CODE_ENTER);
			else if (pick < 95)
				queue_delete();
			else
				queue_noise();
		end

		// Erasing phase: deletes dominate so the line shrinks back down.
		repeat (60) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				queue_delete();
			else if (pick < 80)
				scan_bytes.push_back(pick_char_code());
			else
				queue_noise();
		end
		total_bytes = scan_bytes.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (beats_taken != total_bytes)
			@(posedge clk);
		while (expected_edits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog: far longer than the slowest correct run needs.
	initial begin
		#4_000_000;
		$display("%0t: timeout with %0d results outstanding", $time, expected_edits.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
